// ===== design/rau_pkg.sv =====
// rational arithmetic unit package: widths, operation codes and shared types
// no dependencies
package rau_pkg;

  localparam int unsigned OperandWidth = 16;
  localparam int unsigned MagWidth     = 2 * OperandWidth + 1;
  localparam int unsigned NumWidth     = 33;
  localparam int unsigned DenWidth     = 31;
  localparam int unsigned OrdWidth     = 2;
  localparam int unsigned KindWidth    = 3;
  localparam int unsigned CntWidth     = $clog2(MagWidth + 1);

  localparam logic [KindWidth-1:0] KindAdd = 3'd0;
  localparam logic [KindWidth-1:0] KindSub = 3'd1;
  localparam logic [KindWidth-1:0] KindMul = 3'd2;
  localparam logic [KindWidth-1:0] KindDiv = 3'd3;
  localparam logic [KindWidth-1:0] KindCmp = 3'd4;

  typedef logic [MagWidth-1:0] mag_t;

  typedef struct packed {
    logic start;
    mag_t dividend;
    mag_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    mag_t quot;
    mag_t rem;
  } div_rsp_t;

endpackage

// ===== design/rational_arithmetic_unit_top.sv =====
// rational arithmetic unit top level: sequencer, shared divider
// depends on rau_pkg and rau_div
//
// usage: one input word carries kind and two fractions a_num/a_den, b_num/b_den.
// zero denominators read as 0/1. add, subtract, multiply and divide give a
// reduced fraction with positive denominator; compare gives order (sign of a-b)
// with res 0/1. one result word per input word.
// computation: 33-bit euclid gcd then two exact divisions, all on one shared
// restoring divider; compare and zero results skip the divider.
// in_ready_o is high only when the unit is idle; the next word is taken once
// the result register is empty or being read, so a stalled receiver holds
// the result and blocks new input. reset clears all control state; the unit
// is ready right after reset.
module rational_arithmetic_unit_top
  import rau_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [KindWidth-1:0]       kind_i,
  input  logic signed [OperandWidth-1:0] a_num_i,
  input  logic signed [OperandWidth-1:0] a_den_i,
  input  logic signed [OperandWidth-1:0] b_num_i,
  input  logic signed [OperandWidth-1:0] b_den_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [NumWidth-1:0] res_num_o,
  output logic [DenWidth-1:0]        res_den_o,
  output logic signed [OrdWidth-1:0] order_o
);

  typedef enum logic [2:0] {
    StIdle, StMul, StSum, StGcd, StGcdWait, StDivN, StDivD, StOut
  } state_e;

  localparam int unsigned PW = 2 * OperandWidth;

  state_e state_q;
  logic [KindWidth-1:0] kind_q;
  logic [OperandWidth:0] an_q, ad_q, bn_q, bd_q;  // sign-magnitude, sign at top
  logic [PW:0] p0_q, p1_q, p2_q;                  // sign + magnitude products
  logic        nneg_q, rneg_q;
  mag_t        nm_q, dm_q, x_q, y_q, g_q, qn_q;
  logic        out_valid_q;
  logic signed [NumWidth-1:0] res_num_q;
  logic [DenWidth-1:0]        res_den_q;
  logic signed [OrdWidth-1:0] order_q;
  logic [1:0]  mstep_q;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [OperandWidth:0] mul_x, mul_y;
  logic [PW-1:0] mul_p;
  logic [OperandWidth:0] sa_n, sa_d, sb_n, sb_d;
  logic        az, bz;

  assign mul_p = PW'(mul_x[OperandWidth-1:0]) * PW'(mul_y[OperandWidth-1:0]);

  always_comb begin
    sa_n = {a_num_i[OperandWidth-1],
            a_num_i[OperandWidth-1] ? (~a_num_i + 1'b1) : a_num_i};
    sa_d = {a_den_i[OperandWidth-1],
            a_den_i[OperandWidth-1] ? (~a_den_i + 1'b1) : a_den_i};
    sb_n = {b_num_i[OperandWidth-1],
            b_num_i[OperandWidth-1] ? (~b_num_i + 1'b1) : b_num_i};
    sb_d = {b_den_i[OperandWidth-1],
            b_den_i[OperandWidth-1] ? (~b_den_i + 1'b1) : b_den_i};
    az   = (a_den_i == '0);
    bz   = (b_den_i == '0);
  end

  // most negative operand: magnitude 2^(w-1) lands in the low w bits correctly,
  // the sign bit is the top bit kept separately
  always_comb begin
    mul_x = an_q;
    mul_y = bd_q;
    case (mstep_q)
      2'd0: begin
        mul_x = an_q;
        mul_y = (kind_q == KindMul || kind_q == KindDiv) ? bn_q : bd_q;
      end
      2'd1: begin
        mul_x = bn_q;
        mul_y = ad_q;
      end
      default: begin
        mul_x = ad_q;
        mul_y = bd_q;
      end
    endcase
  end

  logic [PW:0] pr;
  assign pr = {(mul_p != '0) && (mul_x[OperandWidth] != mul_y[OperandWidth]), mul_p};

  logic        sum_neg;
  logic [PW:0] sum_mag;
  always_comb begin
    if (p0_q[PW] == p1_q[PW]) begin
      sum_mag = {1'b0, p0_q[PW-1:0]} + {1'b0, p1_q[PW-1:0]};
      sum_neg = p0_q[PW];
    end else if (p0_q[PW-1:0] >= p1_q[PW-1:0]) begin
      sum_mag = {1'b0, p0_q[PW-1:0] - p1_q[PW-1:0]};
      sum_neg = p0_q[PW];
    end else begin
      sum_mag = {1'b0, p1_q[PW-1:0] - p0_q[PW-1:0]};
      sum_neg = p1_q[PW];
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  logic [OperandWidth:0] b_rn, b_rd;
  always_comb begin
    b_rn = sb_n;
    b_rd = bz ? {1'b0, OperandWidth'(1)} : sb_d;
    if (bz) b_rn = '0;
    if ((kind_i == KindSub || kind_i == KindCmp) && b_rn[OperandWidth-1:0] != '0)
      b_rn[OperandWidth] = ~b_rn[OperandWidth];
    if (kind_i == KindDiv) begin
      if (b_rn[OperandWidth-1:0] == '0) begin
        b_rn = '0;
        b_rd = {1'b0, OperandWidth'(1)};
      end else begin
        b_rn = b_rd;
        b_rd = bz ? {1'b0, OperandWidth'(1)} : sb_n;
      end
    end
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = x_q;
    dreq.divisor  = y_q;
    if (state_q == StGcd) begin
      dreq.start = (kind_q <= KindDiv) && (x_q != '0) && (y_q != '0);
    end else if (state_q == StGcdWait && drsp.done && drsp.rem != '0) begin
      dreq.start    = 1'b1;
      dreq.dividend = y_q;
      dreq.divisor  = drsp.rem;
    end else if (state_q == StGcdWait && drsp.done) begin
      dreq.start    = 1'b1;
      dreq.dividend = nm_q;
      dreq.divisor  = y_q;
    end else if (state_q == StDivN && drsp.done) begin
      dreq.start    = 1'b1;
      dreq.dividend = dm_q;
      dreq.divisor  = g_q;
    end
  end

  rau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      mstep_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            state_q <= StMul;
            mstep_q <= 2'd0;
          end
        end
        StMul: begin
          mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 2'd2) state_q <= StSum;
        end
        StSum: begin
          state_q <= StGcd;
        end
        StGcd: begin
          if (kind_q == KindCmp || !(kind_q <= KindDiv) || y_q == '0 || x_q == '0) begin
            state_q     <= StIdle;
            out_valid_q <= 1'b1;
          end else begin
            state_q <= StGcdWait;
          end
        end
        StGcdWait: begin
          if (drsp.done && drsp.rem == '0) state_q <= StDivN;
        end
        StDivN: begin
          if (drsp.done) state_q <= StDivD;
        end
        StDivD: begin
          if (drsp.done) state_q <= StOut;
        end
        StOut: begin
          state_q     <= StIdle;
          out_valid_q <= 1'b1;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          kind_q <= kind_i;
          an_q   <= az ? '0 : ((a_num_i == '0) ? '0 : sa_n);
          ad_q   <= az ? {1'b0, OperandWidth'(1)} : sa_d;
          bn_q   <= (b_rn[OperandWidth-1:0] == '0) ? '0 : b_rn;
          bd_q   <= b_rd;
        end
      end
      StMul: begin
        case (mstep_q)
          2'd0:    p0_q <= pr;
          2'd1:    p1_q <= pr;
          default: p2_q <= pr;
        endcase
      end
      StSum: begin
        if (kind_q == KindMul || kind_q == KindDiv) begin
          nneg_q <= p0_q[PW];
          x_q    <= MagWidth'(p0_q[PW-1:0]);
          nm_q   <= MagWidth'(p0_q[PW-1:0]);
        end else begin
          nneg_q <= sum_neg;
          x_q    <= MagWidth'(sum_mag);
          nm_q   <= MagWidth'(sum_mag);
        end
        y_q  <= MagWidth'(p2_q[PW-1:0]);
        dm_q <= MagWidth'(p2_q[PW-1:0]);
      end
      StGcd: begin
        rneg_q    <= nneg_q != p2_q[PW];
        res_num_q <= '0;
        res_den_q <= DenWidth'(1);
        order_q   <= '0;
        if (kind_q == KindCmp && x_q != '0)
          order_q <= (nneg_q != p2_q[PW]) ? -OrdWidth'(1) : OrdWidth'(1);
      end
      StGcdWait: begin
        if (drsp.done) begin
          if (drsp.rem != '0) begin
            y_q <= drsp.rem;
          end else begin
            g_q <= y_q;
          end
        end
      end
      StDivN: begin
        if (drsp.done) qn_q <= drsp.quot;
      end
      StDivD: begin
        if (drsp.done) begin
          res_den_q <= DenWidth'(drsp.quot);
          res_num_q <= rneg_q ? NumWidth'(-qn_q) : NumWidth'(qn_q);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign order_o     = order_q;

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_ready_o) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(res_num_q))
    else $error("result lost");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == StMul) else $error("accept missed");
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> res_den_q != '0) else $error("zero denominator");
`endif

endmodule

// ===== design/rau_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on rau_pkg
module rau_div
  import rau_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  mag_t                q_q, q_d;
  mag_t                r_q, r_d;
  mag_t                dv_q, dv_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [MagWidth:0]   trial;

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    dv_d   = dv_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {r_q, q_q[MagWidth-1]} - {1'b0, dv_q};
    if (req_i.start) begin
      q_d    = req_i.dividend;
      r_d    = '0;
      dv_d   = req_i.divisor;
      cnt_d  = CntWidth'(MagWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[MagWidth]) begin
        r_d = {r_q[MagWidth-2:0], q_q[MagWidth-1]};
        q_d = {q_q[MagWidth-2:0], 1'b0};
      end else begin
        r_d = trial[MagWidth-1:0];
        q_d = {q_q[MagWidth-2:0], 1'b1};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    r_q  <= r_d;
    dv_q <= dv_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;
  assign rsp_o.rem  = r_q;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("busy with zero count");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !req_i.start |=> busy_q || done_q) else $error("divider lost");
`endif

endmodule

// ===== test/rau_checker.sv =====
// checker for the rational arithmetic unit: watches both channels, predicts each result
// word from the accepted input word and compares in order; depends on rau_pkg
`timescale 1ns / 100ps

module rau_checker
  import rau_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [KindWidth-1:0]           kind_i,
  input  logic signed [OperandWidth-1:0] a_num_i,
  input  logic signed [OperandWidth-1:0] a_den_i,
  input  logic signed [OperandWidth-1:0] b_num_i,
  input  logic signed [OperandWidth-1:0] b_den_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic signed [NumWidth-1:0]     res_num_i,
  input  logic [DenWidth-1:0]            res_den_i,
  input  logic signed [OrdWidth-1:0]     order_i,
  output int                             errors_o,
  output int                             pending_o
);

  typedef struct packed {
    logic signed [NumWidth-1:0] num;
    logic [DenWidth-1:0]        den;
    logic signed [OrdWidth-1:0] ord;
  } rat_result_t;

  rat_result_t expected_q[$];

  function automatic rat_result_t rational_op(logic [KindWidth-1:0] kind,
                                              longint an, longint ad,
                                              longint bn, longint bd);
    rat_result_t r;
    longint n, d, x, y, t, g;
    r.num = '0;
    r.den = DenWidth'(1);
    r.ord = '0;
    if (ad == 0) begin
      an = 0;
      ad = 1;
    end
    if (bd == 0) begin
      bn = 0;
      bd = 1;
    end
    if (kind == KindSub || kind == KindCmp) bn = -bn;
    if (kind == KindDiv) begin
      if (bn == 0) begin
        bd = 1;
      end else begin
        t  = bn;
        bn = bd;
        bd = t;
      end
    end
    if (kind == KindAdd || kind == KindSub || kind == KindCmp) n = an * bd + bn * ad;
    else n = an * bn;
    d = ad * bd;
    if (kind == KindCmp) begin
      if (n != 0) r.ord = OrdWidth'(((n < 0) != (d < 0)) ? -1 : 1);
    end else if (kind <= KindDiv && n != 0) begin
      x = (n < 0) ? -n : n;
      y = (d < 0) ? -d : d;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      g = x;
      x = ((n < 0) ? -n : n) / g;
      r.num = NumWidth'(((n < 0) != (d < 0)) ? -x : x);
      r.den = DenWidth'(((d < 0) ? -d : d) / g);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rat_result_t e;
    if (!rst_ni) begin
      expected_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result word %0d/%0d order %0d",
                                      res_num_i, res_den_i, order_i);
          errors_o <= errors_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.num !== res_num_i || e.den !== res_den_i || e.ord !== order_i) begin
            if (errors_o < 10)
              $display("mismatch: expected %0d/%0d order %0d, got %0d/%0d order %0d",
                       e.num, e.den, e.ord, res_num_i, res_den_i, order_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(rational_op(kind_i, a_num_i, a_den_i, b_num_i, b_den_i));
      pending_o <= expected_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// testbench for rational_arithmetic_unit_top: directed and random fraction words
// with bursty input and a stalling receiver; depends on rau_pkg, the dut and rau_checker
`timescale 1ns / 100ps

module testbench;
  import rau_pkg::*;

  localparam int NumRandom = 1630;
  localparam int IdleLimit = 20000;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [KindWidth-1:0]           kind;
  logic signed [OperandWidth-1:0] a_num, a_den, b_num, b_den;
  logic                           out_valid;
  logic                           out_ready;
  logic signed [NumWidth-1:0]     res_num;
  logic [DenWidth-1:0]            res_den;
  logic signed [OrdWidth-1:0]     order;
  int                             errors, pending, words_sent, idle_cycles;

  rational_arithmetic_unit_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .a_num_i(a_num), .a_den_i(a_den), .b_num_i(b_num), .b_den_i(b_den),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .res_num_o(res_num), .res_den_o(res_den), .order_o(order)
  );

  rau_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .kind_i(kind), .a_num_i(a_num), .a_den_i(a_den), .b_num_i(b_num), .b_den_i(b_den),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .res_num_i(res_num), .res_den_i(res_den), .order_i(order),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [OperandWidth-1:0] pick_operand();
    int m;
    m = $urandom_range(0, 9);
    case (m)
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'hffff;
        endcase
      end
      1, 2, 3: return OperandWidth'(int'($urandom_range(0, 40)) - 20);
      default: return OperandWidth'($urandom);
    endcase
  endfunction

  task automatic drive_word(logic [KindWidth-1:0] k, logic [OperandWidth-1:0] an,
                            logic [OperandWidth-1:0] ad, logic [OperandWidth-1:0] bn,
                            logic [OperandWidth-1:0] bd);
    in_valid <= 1'b1;
    kind     <= k;
    a_num    <= an;
    a_den    <= ad;
    b_num    <= bn;
    b_den    <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // receiver: ready pattern picked at random from four modes, one long hold-off mid run
  initial begin
    int cyc, mode, hold;
    bit held;
    out_ready = 1'b0;
    cyc  = 0;
    mode = 0;
    hold = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (!held && words_sent >= 200) begin
        held = 1'b1;
        hold = 4000;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    int burst, gap, k;
    in_valid     = 1'b0;
    kind         = '0;
    a_num        = '0;
    a_den        = '0;
    b_num        = '0;
    b_den        = '0;
    words_sent   = 0;
    rst_n        = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed words
    drive_word(KindAdd, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    drive_word(KindSub, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
    drive_word(KindMul, -16'sd3, 16'sd4, 16'sd2, -16'sd9);
    drive_word(KindDiv, 16'sd5, 16'sd7, -16'sd10, 16'sd21);
    drive_word(KindCmp, 16'sd1, 16'sd3, 16'sd1, 16'sd2);
    drive_word(KindCmp, 16'sd2, 16'sd4, 16'sd1, 16'sd2);
    drive_word(KindCmp, -16'sd1, -16'sd3, 16'sd1, -16'sd2);
    drive_word(KindAdd, 16'sd5, 16'sd0, 16'sd3, 16'sd4);
    drive_word(KindMul, 16'sd5, 16'sd6, 16'sd3, 16'sd0);
    drive_word(KindDiv, 16'sd5, 16'sd6, 16'sd0, 16'sd7);
    drive_word(KindDiv, 16'sd5, 16'sd6, 16'sd3, 16'sd0);
    drive_word(KindAdd, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    drive_word(KindSub, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    drive_word(KindMul, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    drive_word(KindDiv, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    drive_word(KindCmp, 16'h8000, 16'h0001, 16'h7fff, 16'h0001);
    drive_word(KindAdd, 16'h7fff, 16'h0001, 16'h7fff, 16'h0001);
    drive_word(KindSub, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    drive_word(KindAdd, 16'sd0, 16'sd5, 16'sd0, -16'sd7);
    drive_word(3'd5, 16'sd3, 16'sd4, 16'sd5, 16'sd6);
    drive_word(3'd6, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    drive_word(3'd7, -16'sd1, -16'sd1, -16'sd1, -16'sd1);

    // random words in bursts
    burst = $urandom_range(1, 8);
    for (int i = 0; i < NumRandom; i++) begin
      k = $urandom_range(0, 19);
      drive_word((k < 18) ? KindWidth'(k % 5) : KindWidth'(5 + $urandom_range(0, 2)),
                 pick_operand(), pick_operand(), pick_operand(), pick_operand());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    in_valid     <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
